[sv/lbpr_pkg.sv]
package lbpr_pkg;

   // Fixed geometry of the sampling circle
   localparam int SAMPLE_POINTS = 8;
   localparam int DIAG_POINTS   = 4;

   // Q1.8 weights, 9 bits so that 1.0 (256) and above can be written
   localparam int WEIGHT_BITS = 9;
   localparam int Q_FRAC_BITS = 8;

   // Result field width and the non-uniform code
   localparam int COUNT_BITS = 4;
   localparam int UNIFORM_LIMIT = 2;
   localparam logic [COUNT_BITS-1:0] CATEGORY_NON_UNIFORM = 4'd9;

   // Register file
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [SAMPLE_POINTS-1:0] sample_bits_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTRE_WEIGHT = 2'd0,
      CSR_EDGE_WEIGHT   = 2'd1,
      CSR_CORNER_WEIGHT = 2'd2
   } csr_index_type;

   localparam weight_type CENTRE_WEIGHT_RESET = 9'd22;
   localparam weight_type EDGE_WEIGHT_RESET   = 9'd53;
   localparam weight_type CORNER_WEIGHT_RESET = 9'd128;

   typedef struct packed {
      count_type category;
      count_type ones_count;
      count_type transition_count;
   } result_type;

endpackage

[sv/lbpr_if.sv]
interface lbpr_req_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] centre_pixel;
   logic [PIXEL_BITS-1:0] east_pixel;
   logic [PIXEL_BITS-1:0] south_east_pixel;
   logic [PIXEL_BITS-1:0] south_pixel;
   logic [PIXEL_BITS-1:0] south_west_pixel;
   logic [PIXEL_BITS-1:0] west_pixel;
   logic [PIXEL_BITS-1:0] north_west_pixel;
   logic [PIXEL_BITS-1:0] north_pixel;
   logic [PIXEL_BITS-1:0] north_east_pixel;

   modport source (
      output valid, centre_pixel, east_pixel, south_east_pixel, south_pixel,
             south_west_pixel, west_pixel, north_west_pixel, north_pixel,
             north_east_pixel,
      input  ready
   );
   modport sink (
      input  valid, centre_pixel, east_pixel, south_east_pixel, south_pixel,
             south_west_pixel, west_pixel, north_west_pixel, north_pixel,
             north_east_pixel,
      output ready
   );
endinterface

interface lbpr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lbpr_pkg::COUNT_BITS-1:0] category;
   logic [lbpr_pkg::COUNT_BITS-1:0] ones_count;
   logic [lbpr_pkg::COUNT_BITS-1:0] transition_count;

   modport source (output valid, category, ones_count, transition_count, input ready);
   modport sink   (input  valid, category, ones_count, transition_count, output ready);
endinterface

interface lbpr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lbpr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [lbpr_pkg::WEIGHT_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input  valid, index, data, output ready);
endinterface

[sv/lbpr_pattern.sv]
module lbpr_pattern (
   input  lbpr_pkg::sample_bits_type sample_bits,
   output lbpr_pkg::result_type      result
);
   import lbpr_pkg::*;

   count_type ones;
   count_type trans;
   sample_bits_type changed;

   // Mark each position that differs from its predecessor on the circle
   assign changed = sample_bits ^ {sample_bits[SAMPLE_POINTS-2:0],
                                   sample_bits[SAMPLE_POINTS-1]};

   // Count ones and transitions
   always_comb begin
      ones  = '0;
      trans = '0;
      for (int i = 0; i < SAMPLE_POINTS; i++) begin
         ones  = ones + count_type'(sample_bits[i]);
         trans = trans + count_type'(changed[i]);
      end
   end

   // Uniform patterns keep their ones count, others fold into one code
   always_comb begin
      result.ones_count       = ones;
      result.transition_count = trans;
      if (trans > count_type'(UNIFORM_LIMIT)) begin
         result.category = CATEGORY_NON_UNIFORM;
      end else begin
         result.category = ones;
      end
   end

endmodule

[sv/lbp_uniform_rotation_invariant_code_top.sv]
// Channel   Direction  Handshake     Payload
// req_bus   in         valid/ready   nine pixels of a 3x3 window
// rsp_bus   out        valid/ready   category, ones_count, transition_count
// csr_bus   in         valid/ready   register index, 9-bit weight
//
// One window per cycle sustained while rsp_bus.ready stays high; a result
// passes the input register, product register and result register before
// it is valid on rsp_bus.
// The three stages advance independently; a stalled result holds its stage,
// and req_bus.ready drops only once every stage behind it is full.
// Reset clears the stage valids and loads the default weights.
// csr_bus.ready is always high; writes to an index past the list are ignored.
module lbp_uniform_rotation_invariant_code_top #(
   parameter int PIXEL_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   lbpr_req_if.sink     req_bus,
   lbpr_rsp_if.source   rsp_bus,
   lbpr_csr_if.sink     csr_bus
);
   import lbpr_pkg::*;

   localparam int TERM_BITS      = WEIGHT_BITS + PIXEL_BITS;
   localparam int EDGE_TERM_BITS = TERM_BITS + 1;
   localparam int SUM_BITS       = TERM_BITS + 2;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type c;
      pixel_type e;
      pixel_type se;
      pixel_type s;
      pixel_type sw;
      pixel_type w;
      pixel_type nw;
      pixel_type n;
      pixel_type ne;
   } window_type;

   // Weight registers
   weight_type centre_weight_ff;
   weight_type edge_weight_ff;
   weight_type corner_weight_ff;

   // Stage valids and advance enables
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic adv1, adv2, adv3;

   // Stage payloads
   window_type                win_ff;
   pixel_type                 centre_ff;
   logic [DIAG_POINTS-1:0]    axis_ff, axis_in;
   logic [TERM_BITS-1:0]      cterm_ff, cterm_in;
   logic [EDGE_TERM_BITS-1:0] eterm_ff [DIAG_POINTS];
   logic [EDGE_TERM_BITS-1:0] eterm_in [DIAG_POINTS];
   logic [TERM_BITS-1:0]      kterm_ff [DIAG_POINTS];
   logic [TERM_BITS-1:0]      kterm_in [DIAG_POINTS];
   result_type                result_ff, result_in;

   pixel_type                 edge_a   [DIAG_POINTS];
   pixel_type                 edge_b   [DIAG_POINTS];
   pixel_type                 corner   [DIAG_POINTS];
   logic [DIAG_POINTS-1:0]    diag_bits;
   sample_bits_type           sample_bits;

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_weight_ff <= CENTRE_WEIGHT_RESET;
         edge_weight_ff   <= EDGE_WEIGHT_RESET;
         corner_weight_ff <= CORNER_WEIGHT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_CENTRE_WEIGHT: centre_weight_ff <= csr_bus.data;
            CSR_EDGE_WEIGHT:   edge_weight_ff   <= csr_bus.data;
            CSR_CORNER_WEIGHT: corner_weight_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or the stage after it advances
   assign adv3 = !rsp_valid_ff || rsp_bus.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_bus.ready = adv1;

   always_comb begin
      s1_valid_in  = adv1 ? req_bus.valid : s1_valid_ff;
      s2_valid_in  = adv2 ? s1_valid_ff   : s2_valid_ff;
      rsp_valid_in = adv3 ? s2_valid_ff   : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1: capture the window on transfer
   always_ff @(posedge clock) begin
      if (adv1 && req_bus.valid) begin
         win_ff.c  <= req_bus.centre_pixel;
         win_ff.e  <= req_bus.east_pixel;
         win_ff.se <= req_bus.south_east_pixel;
         win_ff.s  <= req_bus.south_pixel;
         win_ff.sw <= req_bus.south_west_pixel;
         win_ff.w  <= req_bus.west_pixel;
         win_ff.nw <= req_bus.north_west_pixel;
         win_ff.n  <= req_bus.north_pixel;
         win_ff.ne <= req_bus.north_east_pixel;
      end
   end

   // Diagonal neighbors: SE, SW, NW, NE
   always_comb begin
      edge_a[0] = win_ff.e;  edge_b[0] = win_ff.s;  corner[0] = win_ff.se;
      edge_a[1] = win_ff.s;  edge_b[1] = win_ff.w;  corner[1] = win_ff.sw;
      edge_a[2] = win_ff.w;  edge_b[2] = win_ff.n;  corner[2] = win_ff.nw;
      edge_a[3] = win_ff.n;  edge_b[3] = win_ff.e;  corner[3] = win_ff.ne;
   end

   // Axis compares and the weighted terms of each diagonal
   always_comb begin
      axis_in[0] = win_ff.e >= win_ff.c;
      axis_in[1] = win_ff.s >= win_ff.c;
      axis_in[2] = win_ff.w >= win_ff.c;
      axis_in[3] = win_ff.n >= win_ff.c;
      cterm_in   = TERM_BITS'(centre_weight_ff) * TERM_BITS'(win_ff.c);
      for (int k = 0; k < DIAG_POINTS; k++) begin
         eterm_in[k] = EDGE_TERM_BITS'(edge_weight_ff)
                     * (EDGE_TERM_BITS'(edge_a[k]) + EDGE_TERM_BITS'(edge_b[k]));
         kterm_in[k] = TERM_BITS'(corner_weight_ff) * TERM_BITS'(corner[k]);
      end
   end

   // Stage 2: hold products
   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         centre_ff <= win_ff.c;
         axis_ff   <= axis_in;
         cterm_ff  <= cterm_in;
         for (int k = 0; k < DIAG_POINTS; k++) begin
            eterm_ff[k] <= eterm_in[k];
            kterm_ff[k] <= kterm_in[k];
         end
      end
   end

   // Compare each diagonal sum with the centre at the same Q0.8 scale
   always_comb begin
      for (int k = 0; k < DIAG_POINTS; k++) begin
         diag_bits[k] = (SUM_BITS'(cterm_ff) + SUM_BITS'(eterm_ff[k])
                         + SUM_BITS'(kterm_ff[k]))
                        >= (SUM_BITS'(centre_ff) << Q_FRAC_BITS);
      end
   end

   // Interleave axis and diagonal samples, starting east
   always_comb begin
      for (int k = 0; k < DIAG_POINTS; k++) begin
         sample_bits[2*k]   = axis_ff[k];
         sample_bits[2*k+1] = diag_bits[k];
      end
   end

   lbpr_pattern u_pattern (
      .sample_bits (sample_bits),
      .result      (result_in)
   );

   // Stage 3: result register
   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.category         = result_ff.category;
   assign rsp_bus.ones_count       = result_ff.ones_count;
   assign rsp_bus.transition_count = result_ff.transition_count;

endmodule

[sv/lbpr_checker.sv]
module lbpr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lbpr_pkg::count_type       category,
   input lbpr_pkg::count_type       ones_count,
   input lbpr_pkg::count_type       transition_count
);
   import lbpr_pkg::*;

   // A stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(category)
         && $stable(ones_count) && $stable(transition_count))
      else $error("stalled result changed");

   // Category follows the uniformity rule
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((transition_count > count_type'(UNIFORM_LIMIT))
                     ? (category == CATEGORY_NON_UNIFORM)
                     : (category == ones_count)))
      else $error("category does not match counts");

   // Cyclic transitions come in pairs and never exceed the sample count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !transition_count[0]
         && transition_count <= count_type'(SAMPLE_POINTS)
         && ones_count <= count_type'(SAMPLE_POINTS))
      else $error("counts out of range");

   // An all-equal pattern has no transitions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (ones_count == '0 || ones_count == count_type'(SAMPLE_POINTS))
         |-> transition_count == '0)
      else $error("transitions on a flat pattern");

   // No result in the first cycle out of reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lbp_uniform_rotation_invariant_code_top lbpr_checker u_lbpr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .category         (rsp_bus.category),
   .ones_count       (rsp_bus.ones_count),
   .transition_count (rsp_bus.transition_count)
);
